### hw/rtl/rtrt_pkg.sv
// shared types, constants and helpers for the ring transition radius tracker
// no dependencies
package rtrt_pkg;

    localparam int SEQ_LEN   = 32;
    localparam int MAX_STEPS = 1024;

    localparam int STEP_W   = $clog2(MAX_STEPS);
    localparam int PTR_W    = 6;
    localparam int LEVEL_W  = 8;
    localparam int WORD_W   = 64;
    localparam int CODE_W   = 4;
    localparam int LABEL_W  = 4;
    localparam int RADIUS_W = 11;
    localparam int CFG_IDX_W = 2;

    localparam int K_W    = 32;
    localparam int FRAC_W = 31;
    localparam int MUL_W  = (STEP_W + K_W > RADIUS_W + FRAC_W) ?
                            (STEP_W + K_W) : (RADIUS_W + FRAC_W);
    localparam logic [K_W-1:0] SQRT2_Q31 = 32'd3037000499;

    localparam logic [CODE_W-1:0] CODE_LABEL_LIMIT = 4'd11;
    localparam logic [CODE_W-1:0] CODE_BLACK_WHITE = 4'd12;
    localparam logic [CODE_W-1:0] CODE_WHITE_BLACK = 4'd13;
    localparam logic [CODE_W-1:0] CODE_FINISH      = 4'd14;
    localparam logic [CODE_W-1:0] CODE_UNUSED      = 4'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_TH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_TH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_HIGH = 2'd3;

    localparam logic [LEVEL_W-1:0] BLACK_TH_RESET = 8'd64;
    localparam logic [LEVEL_W-1:0] WHITE_TH_RESET = 8'd192;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_TRANS    = 3'd1,
        ST_RING     = 3'd2,
        ST_FINISH   = 3'd3,
        ST_MISMATCH = 3'd4,
        ST_IDLE     = 3'd5
    } t_status;

    typedef struct packed {
        logic [LEVEL_W-1:0] pixel_level;
        logic               scan_start;
        logic               scan_last;
    } t_in_item;

    typedef struct packed {
        t_status             step_status;
        logic [LABEL_W-1:0]  ring_label;
        logic [RADIUS_W-1:0] ring_radius;
        logic                scan_done;
    } t_out_item;

    typedef struct packed {
        logic              white_now;
        logic [PTR_W-1:0]  seq_ptr;
        logic [STEP_W-1:0] step_count;
        logic              halted;
    } t_scan_state;

    typedef struct packed {
        logic [LEVEL_W-1:0] black_th;
        logic [LEVEL_W-1:0] white_th;
        logic [WORD_W-1:0]  seq_low;
        logic [WORD_W-1:0]  seq_high;
    } t_cfg;

    function automatic logic [CODE_W-1:0] entry_at(
        input logic [PTR_W-1:0]  idx,
        input logic [WORD_W-1:0] lo,
        input logic [WORD_W-1:0] hi
    );
        logic [5:0] bit_pos;
        logic [CODE_W-1:0] code;
        bit_pos = {idx[3:0], 2'b00};
        if (idx >= PTR_W'(SEQ_LEN)) begin
            code = CODE_UNUSED;
        end else if (idx[4]) begin
            code = hi[bit_pos +: CODE_W];
        end else begin
            code = lo[bit_pos +: CODE_W];
        end
        return code;
    endfunction

endpackage

### hw/rtl/rtrt_step.sv
// per-sample logic: hysteresis classify, sequence match, label pick, radius multiply
// depends on rtrt_pkg
module rtrt_step (
    input  rtrt_pkg::t_scan_state i_state,
    input  rtrt_pkg::t_cfg        i_cfg,
    input  rtrt_pkg::t_in_item    i_item,
    output rtrt_pkg::t_scan_state o_state,
    output rtrt_pkg::t_out_item   o_item
);
    import rtrt_pkg::*;

    logic              white0;
    logic [PTR_W-1:0]  ptr0;
    logic [STEP_W-1:0] step0;
    logic              halted0;
    logic [CODE_W-1:0] e0;
    logic [CODE_W-1:0] e1;
    logic [CODE_W-1:0] e2;
    logic [PTR_W-1:0]  p1;
    logic [PTR_W-1:0]  p2;
    logic              wb;
    logic              bw;
    logic              white1;
    logic              err1;
    logic              err;
    logic              found;
    logic              done;
    logic [MUL_W-1:0]  prod;

    assign white0  = i_item.scan_start ? 1'b0 : i_state.white_now;
    assign ptr0    = i_item.scan_start ? '0 : i_state.seq_ptr;
    assign step0   = i_item.scan_start ? '0 : i_state.step_count;
    assign halted0 = i_item.scan_start ? 1'b0 : i_state.halted;

    assign p1 = ptr0 + PTR_W'(1);
    assign p2 = ptr0 + PTR_W'(2);
    assign e0 = entry_at(ptr0, i_cfg.seq_low, i_cfg.seq_high);
    assign e1 = entry_at(p1, i_cfg.seq_low, i_cfg.seq_high);
    assign e2 = entry_at(p2, i_cfg.seq_low, i_cfg.seq_high);

    assign wb     = white0 && (i_item.pixel_level < i_cfg.black_th);
    assign white1 = wb ? 1'b0 : white0;
    assign err1   = wb && (e0 != CODE_WHITE_BLACK);
    assign bw     = !err1 && !white1 && (i_item.pixel_level > i_cfg.white_th);
    assign err    = err1 || (bw && (e0 != CODE_BLACK_WHITE));
    assign found  = wb || bw;

    assign prod = MUL_W'(step0) * MUL_W'(SQRT2_Q31);

    always_comb begin
        o_state  = i_state;
        o_item   = '0;
        done     = 1'b0;
        if (halted0) begin
            o_item.step_status = ST_IDLE;
        end else begin
            o_state.white_now  = bw ? 1'b1 : white1;
            o_state.seq_ptr    = ptr0;
            o_item.step_status = ST_NONE;
            if (err) begin
                o_item.step_status = ST_MISMATCH;
                done = 1'b1;
            end else if (found) begin
                o_item.step_status = ST_TRANS;
                o_state.seq_ptr    = p1;
                if (p1 >= PTR_W'(SEQ_LEN)) begin
                    done = 1'b1;
                end else if (e1 < CODE_LABEL_LIMIT) begin
                    o_item.step_status = ST_RING;
                    o_item.ring_label  = e1;
                    o_item.ring_radius = prod[FRAC_W +: RADIUS_W];
                    o_state.seq_ptr    = p2;
                    if (p2 >= PTR_W'(SEQ_LEN)) begin
                        done = 1'b1;
                    end else if (e2 == CODE_FINISH) begin
                        o_item.step_status = ST_FINISH;
                        done = 1'b1;
                    end
                end
            end
            if (i_item.scan_last || (step0 >= STEP_W'(MAX_STEPS - 1))) begin
                done = 1'b1;
            end
            o_item.scan_done = done;
            if (done) begin
                o_state.halted     = 1'b1;
                o_state.step_count = step0;
            end else begin
                o_state.halted     = 1'b0;
                o_state.step_count = step0 + STEP_W'(1);
            end
        end
    end

endmodule

### hw/rtl/ring_transition_radius_tracker_unit.sv
// top level: config registers, scan state, result register and handshakes
// depends on rtrt_pkg and rtrt_step
// latency: the result of an accepted sample is shown the cycle after it is accepted
// throughput: one sample per cycle unless the output is stalled; the scan state register is updated at each accept
// a stalled result waits in the output register; the next sample is taken when it drains
// reset (synchronous, active low) loads default thresholds, clears the description
// and leaves the scan halted until a sample with scan_start
module ring_transition_radius_tracker_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rtrt_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rtrt_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rtrt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rtrt_pkg::WORD_W-1:0]         i_cfg_data
);
    import rtrt_pkg::*;

    t_cfg        r_cfg;
    t_scan_state r_state;
    t_scan_state n_state;
    t_out_item   r_out;
    t_out_item   n_out;
    logic        r_out_valid;
    logic        in_beat;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_beat     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    rtrt_step u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_item  (i_in_data),
        .o_state (n_state),
        .o_item  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.black_th <= BLACK_TH_RESET;
            r_cfg.white_th <= WHITE_TH_RESET;
            r_cfg.seq_low  <= '0;
            r_cfg.seq_high <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BLACK_TH: r_cfg.black_th <= i_cfg_data[LEVEL_W-1:0];
                CFG_WHITE_TH: r_cfg.white_th <= i_cfg_data[LEVEL_W-1:0];
                CFG_SEQ_LOW:  r_cfg.seq_low  <= i_cfg_data;
                CFG_SEQ_HIGH: r_cfg.seq_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.white_now  <= 1'b0;
            r_state.seq_ptr    <= '0;
            r_state.step_count <= '0;
            r_state.halted     <= 1'b1;
            r_out_valid        <= 1'b0;
        end else begin
            if (in_beat) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out <= n_out;
        end
    end

endmodule
